/* rtl/ntd_pkg.sv */
// ----------------------------------------------------------------------------
// ntd_pkg: note word to tone decoder package
// Field widths, register codes, reciprocal constants, the tone table and the
// structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package ntd_pkg;

  localparam int unsigned NoteW    = 16;
  localparam int unsigned FreqW    = 12;
  localparam int unsigned ReloadW  = 32;
  localparam int unsigned CmpW     = 26;
  localparam int unsigned SoundW   = 16;
  localparam int unsigned SilenceW = 14;
  localparam int unsigned BeatW    = 17;
  localparam int unsigned DenW     = 28;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned DataW    = 32;

  localparam int unsigned OctCenter = 5;
  localparam int unsigned OctRows   = 7;
  localparam int unsigned StepCols  = 7;

  // floor(x / d) == (x * Recip) >> Shift over the value range used
  localparam logic [15:0] Recip10     = 16'd52429;
  localparam int unsigned Shift10     = 19;
  localparam logic [16:0] Recip100    = 17'd83887;
  localparam int unsigned Shift100    = 23;
  localparam logic [16:0] Recip1000   = 17'd67109;
  localparam int unsigned Shift1000   = 26;
  localparam logic [18:0] Recip5      = 19'd419431;
  localparam int unsigned Shift5      = 21;
  localparam logic [31:0] RecipPulse  = 32'd2748779070;
  localparam int unsigned ShiftPulse  = 38;

  typedef enum logic [1:0] {
    REG_KEY_OCTAVE     = 2'd0,
    REG_BASE_NOTE_MS   = 2'd1,
    REG_TIMER_CLOCK_HZ = 2'd2,
    REG_TONE_PRESCALER = 2'd3
  } ntd_reg_e;

  localparam logic [FreqW-1:0] ToneTable [OctRows][StepCols] = '{
    '{12'd33,   12'd37,   12'd41,   12'd46,   12'd49,   12'd55,   12'd61},
    '{12'd65,   12'd73,   12'd82,   12'd92,   12'd98,   12'd110,  12'd123},
    '{12'd130,  12'd146,  12'd164,  12'd185,  12'd196,  12'd220,  12'd246},
    '{12'd262,  12'd294,  12'd330,  12'd370,  12'd392,  12'd440,  12'd494},
    '{12'd523,  12'd587,  12'd659,  12'd740,  12'd784,  12'd880,  12'd987},
    '{12'd1047, 12'd1175, 12'd1319, 12'd1480, 12'd1568, 12'd1760, 12'd1976},
    '{12'd2093, 12'd2349, 12'd2637, 12'd2960, 12'd3136, 12'd3520, 12'd3951}
  };

  typedef struct packed {
    logic [2:0]       row;
    logic [2:0]       col;
    logic             rest;
    logic             bad_idx;
    logic             hold;
    logic [BeatW-1:0] beat;
  } ntd_dec_t;

  typedef struct packed {
    logic                hold;
    logic                play;
    logic                bad_idx;
    logic [FreqW-1:0]    freq;
    logic [SoundW-1:0]   sound_ms;
    logic [SilenceW-1:0] silence_ms;
  } ntd_tag_t;

  typedef struct packed {
    logic                tone_on;
    logic [FreqW-1:0]    tone_freq_hz;
    logic [ReloadW-1:0]  period_reload;
    logic [CmpW-1:0]     compare_value;
    logic [SoundW-1:0]   sound_ms;
    logic [SilenceW-1:0] silence_ms;
    logic                hold_tone;
    logic                bad_note;
  } ntd_res_t;

endpackage

/* rtl/ntd_note_if.sv */
// ----------------------------------------------------------------------------
// ntd_note_if: note word request channel
// Valid/ready channel carrying one decimal-coded note word.
// ----------------------------------------------------------------------------
interface ntd_note_if import ntd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NoteW-1:0] note_word;

  modport source (output valid, output note_word, input ready);
  modport sink   (input valid, input note_word, output ready);
endinterface

/* rtl/ntd_tone_if.sv */
// ----------------------------------------------------------------------------
// ntd_tone_if: tone request channel
// Valid/ready channel carrying one decoded tone request.
// ----------------------------------------------------------------------------
interface ntd_tone_if import ntd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                tone_on;
  logic [FreqW-1:0]    tone_freq_hz;
  logic [ReloadW-1:0]  period_reload;
  logic [CmpW-1:0]     compare_value;
  logic [SoundW-1:0]   sound_ms;
  logic [SilenceW-1:0] silence_ms;
  logic                hold_tone;
  logic                bad_note;

  modport source (output valid, output tone_on, output tone_freq_hz, output period_reload,
                  output compare_value, output sound_ms, output silence_ms,
                  output hold_tone, output bad_note, input ready);
  modport sink   (input valid, input tone_on, input tone_freq_hz, input period_reload,
                  input compare_value, input sound_ms, input silence_ms,
                  input hold_tone, input bad_note, output ready);
endinterface

/* rtl/ntd_decode.sv */
// ----------------------------------------------------------------------------
// ntd_decode: note word digit split
// Three stages: reciprocal quotients, digit extraction, octave row and beat.
// ----------------------------------------------------------------------------
module ntd_decode import ntd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       key_octave_i,
  input  logic [12:0]      base_note_ms_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NoteW-1:0] note_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ntd_dec_t         out_o
);

  logic             v1_q, v2_q, v3_q;
  logic             rdy1, rdy2, rdy3;
  logic [NoteW-1:0] w1_q;
  logic [12:0]      q10_q;
  logic [9:0]       q100_q;
  logic [6:0]       q1000_q;
  logic [3:0]       step2_q, oct2_q, len2_q;
  logic             hold2_q;
  ntd_dec_t         dec3_q;

  logic [31:0] prod10;
  logic [32:0] prod100, prod1000;
  logic [15:0] tens_w;
  logic [12:0] tens_q10;
  logic [9:0]  tens_q100;
  logic [15:0] step_full;
  logic [12:0] oct_full;
  logic [9:0]  len_full;
  logic [4:0]  oct_sum;
  logic        in_rng;
  ntd_dec_t    dec_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign prod10   = 32'(note_word_i) * 32'(Recip10);
  assign prod100  = 33'(note_word_i) * 33'(Recip100);
  assign prod1000 = 33'(note_word_i) * 33'(Recip1000);

  assign tens_w    = 16'(q10_q) * 16'd10;
  assign tens_q10  = 13'(q100_q) * 13'd10;
  assign tens_q100 = 10'(q1000_q) * 10'd10;
  assign step_full = w1_q - tens_w;
  assign oct_full  = q10_q - tens_q10;
  assign len_full  = q100_q - tens_q100;

  always_comb begin
    oct_sum       = 5'(key_octave_i) + 5'(oct2_q);
    in_rng        = (oct_sum >= 5'(OctCenter)) && (oct_sum < 5'(OctCenter + OctRows));
    dec_d.rest    = (step2_q == 4'd0);
    dec_d.bad_idx = !dec_d.rest && (!in_rng || (step2_q > 4'(StepCols)));
    dec_d.row     = 3'(oct_sum - 5'(OctCenter));
    dec_d.col     = 3'(step2_q - 4'd1);
    dec_d.hold    = hold2_q;
    dec_d.beat    = 17'(base_note_ms_i) * 17'(len2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      w1_q    <= note_word_i;
      q10_q   <= prod10[31:Shift10];
      q100_q  <= prod100[32:Shift100];
      q1000_q <= prod1000[32:Shift1000];
    end
    if (rdy2 && v1_q) begin
      step2_q <= step_full[3:0];
      oct2_q  <= oct_full[3:0];
      len2_q  <= len_full[3:0];
      hold2_q <= (q1000_q != 7'd0);
    end
    if (rdy3 && v2_q) begin
      dec3_q <= dec_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = dec3_q;

endmodule

/* rtl/ntd_lookup.sv */
// ----------------------------------------------------------------------------
// ntd_lookup: tone table and note timing
// Two stages: table lookup with sound time, then silence and divisor.
// ----------------------------------------------------------------------------
module ntd_lookup import ntd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     tone_prescaler_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ntd_dec_t        in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ntd_tag_t        out_tag_o,
  output logic [DenW-1:0] out_den_o
);

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  logic              play1_q, bad1_q, hold1_q;
  logic [FreqW-1:0]  freq1_q;
  logic [SoundW-1:0] sound1_q;
  logic [BeatW-1:0]  beat1_q;
  ntd_tag_t          tag2_q;
  logic [DenW-1:0]   den2_q;

  logic              play;
  logic [FreqW-1:0]  freq;
  logic [37:0]       prod5;
  logic [FreqW-1:0]  freq_eff;
  logic [28:0]       den_full;
  logic [BeatW-1:0]  silence_full;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign play  = !in_i.rest && !in_i.bad_idx;
  assign freq  = play ? ToneTable[in_i.row][in_i.col] : '0;
  assign prod5 = 38'({in_i.beat, 2'b00}) * 38'(Recip5);

  assign freq_eff     = (freq1_q == '0) ? FreqW'(1) : freq1_q;
  assign den_full     = 29'(freq_eff) * 29'(17'(tone_prescaler_i) + 17'd1);
  assign silence_full = beat1_q - BeatW'(sound1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      play1_q  <= play;
      bad1_q   <= in_i.bad_idx;
      hold1_q  <= in_i.hold;
      freq1_q  <= freq;
      sound1_q <= prod5[Shift5+SoundW-1:Shift5];
      beat1_q  <= in_i.beat;
    end
    if (rdy2 && v1_q) begin
      tag2_q.hold       <= hold1_q;
      tag2_q.play       <= play1_q;
      tag2_q.bad_idx    <= bad1_q;
      tag2_q.freq       <= freq1_q;
      tag2_q.sound_ms   <= sound1_q;
      tag2_q.silence_ms <= silence_full[SilenceW-1:0];
      den2_q            <= den_full[DenW-1:0];
    end
  end

  assign out_valid_o = v2_q;
  assign out_tag_o   = tag2_q;
  assign out_den_o   = den2_q;

endmodule

/* rtl/ntd_div.sv */
// ----------------------------------------------------------------------------
// ntd_div: pipelined restoring divider
// One quotient bit per stage: timer clock divided by the tone divisor.
// ----------------------------------------------------------------------------
module ntd_div import ntd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        dividend_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntd_tag_t           in_tag_i,
  input  logic [DenW-1:0]    in_den_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntd_tag_t           out_tag_o,
  output logic [ReloadW-1:0] out_quo_o
);

  logic               v_q   [DivSteps];
  logic [DenW-1:0]    rem_q [DivSteps];
  logic [ReloadW-1:0] quo_q [DivSteps];
  logic [DenW-1:0]    den_q [DivSteps];
  ntd_tag_t           tag_q [DivSteps];
  logic               rdy   [DivSteps+1];

  assign rdy[DivSteps] = out_ready_i;
  assign in_ready_o    = rdy[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic               v_in;
    logic [DenW-1:0]    rem_in;
    logic [ReloadW-1:0] quo_in;
    logic [DenW-1:0]    den_in;
    ntd_tag_t           tag_in;
    logic [DenW:0]      trial;
    logic [DenW:0]      diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = in_den_i;
      assign tag_in = in_tag_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign trial  = {rem_in, dividend_i[DivSteps-1-k]};
    assign diff   = trial - {1'b0, den_in};
    assign ge     = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        quo_q[k] <= {quo_in[ReloadW-2:0], ge};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign out_valid_o = v_q[DivSteps-1];
  assign out_tag_o   = tag_q[DivSteps-1];
  assign out_quo_o   = quo_q[DivSteps-1];

endmodule

/* rtl/ntd_post.sv */
// ----------------------------------------------------------------------------
// ntd_post: reload and compare values
// Two stages: zero-quotient check and reload, then compare value by 100.
// ----------------------------------------------------------------------------
module ntd_post import ntd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntd_tag_t           in_tag_i,
  input  logic [ReloadW-1:0] in_quo_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntd_res_t           out_o
);

  logic               v1_q, v2_q;
  logic               rdy1, rdy2;
  ntd_tag_t           tag1_q;
  logic               on1_q, bad1_q;
  logic [ReloadW-1:0] reload1_q;
  ntd_res_t           res2_q;

  logic       quo_zero;
  logic       on;
  logic [63:0] prod_cmp;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign quo_zero = (in_quo_i == '0);
  assign on       = in_tag_i.play && !quo_zero;
  assign prod_cmp = 64'(reload1_q) * 64'(RecipPulse);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      tag1_q    <= in_tag_i;
      on1_q     <= on;
      bad1_q    <= in_tag_i.bad_idx || (in_tag_i.play && quo_zero);
      reload1_q <= on ? (in_quo_i - ReloadW'(1)) : '0;
    end
    if (rdy2 && v1_q) begin
      res2_q.tone_on       <= on1_q;
      res2_q.tone_freq_hz  <= on1_q ? tag1_q.freq : '0;
      res2_q.period_reload <= reload1_q;
      res2_q.compare_value <= prod_cmp[ShiftPulse+CmpW-1:ShiftPulse];
      res2_q.sound_ms      <= tag1_q.sound_ms;
      res2_q.silence_ms    <= tag1_q.silence_ms;
      res2_q.hold_tone     <= tag1_q.hold;
      res2_q.bad_note      <= bad1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = res2_q;

endmodule

/* rtl/note_word_to_tone_decoder.sv */
// ----------------------------------------------------------------------------
// note_word_to_tone_decoder: decimal note word to tone timer request
//
//   channel   direction  handshake        payload
//   note_i    in         valid/ready      note_word
//   tone_o    out        valid/ready      tone_on .. bad_note
//   apb       in         psel/penable     key_octave, base_note_ms,
//                                         timer_clock_hz, tone_prescaler
//
// One request per cycle sustained while tone_o.ready holds; the pipeline is the 32-stage
// divider plus 3 decode, 2 lookup and 2 output stages.
// Reset clears every stage valid bit and loads the register defaults.
// A stall holds each occupied stage; empty stages still fill behind it.
// ----------------------------------------------------------------------------
module note_word_to_tone_decoder import ntd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  ntd_note_if.sink          note_i,
  ntd_tone_if.source        tone_o
);

  logic [2:0]  key_octave_q;
  logic [12:0] base_note_ms_q;
  logic [31:0] timer_clock_hz_q;
  logic [15:0] tone_prescaler_q;
  ntd_reg_e    reg_sel;
  logic        cfg_wr;

  logic            dec_valid, dec_ready;
  ntd_dec_t        dec_data;
  logic            lk_valid, lk_ready;
  ntd_tag_t        lk_tag;
  logic [DenW-1:0] lk_den;
  logic               div_valid, div_ready;
  ntd_tag_t           div_tag;
  logic [ReloadW-1:0] div_quo;
  ntd_res_t           res;

  assign pready  = 1'b1;
  assign reg_sel = ntd_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_octave_q     <= 3'd5;
      base_note_ms_q   <= 13'd250;
      timer_clock_hz_q <= 32'd168000000;
      tone_prescaler_q <= 16'd16800;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KEY_OCTAVE:     key_octave_q     <= pwdata[2:0];
        REG_BASE_NOTE_MS:   base_note_ms_q   <= pwdata[12:0];
        REG_TIMER_CLOCK_HZ: timer_clock_hz_q <= pwdata;
        REG_TONE_PRESCALER: tone_prescaler_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_OCTAVE:     prdata = DataW'(key_octave_q);
      REG_BASE_NOTE_MS:   prdata = DataW'(base_note_ms_q);
      REG_TIMER_CLOCK_HZ: prdata = timer_clock_hz_q;
      REG_TONE_PRESCALER: prdata = DataW'(tone_prescaler_q);
      default:            prdata = '0;
    endcase
  end

  ntd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_octave_i   (key_octave_q),
    .base_note_ms_i (base_note_ms_q),
    .in_valid_i     (note_i.valid),
    .in_ready_o     (note_i.ready),
    .note_word_i    (note_i.note_word),
    .out_valid_o    (dec_valid),
    .out_ready_i    (dec_ready),
    .out_o          (dec_data)
  );

  ntd_lookup u_lookup (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tone_prescaler_i (tone_prescaler_q),
    .in_valid_i       (dec_valid),
    .in_ready_o       (dec_ready),
    .in_i             (dec_data),
    .out_valid_o      (lk_valid),
    .out_ready_i      (lk_ready),
    .out_tag_o        (lk_tag),
    .out_den_o        (lk_den)
  );

  ntd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dividend_i  (timer_clock_hz_q),
    .in_valid_i  (lk_valid),
    .in_ready_o  (lk_ready),
    .in_tag_i    (lk_tag),
    .in_den_i    (lk_den),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_tag_o   (div_tag),
    .out_quo_o   (div_quo)
  );

  ntd_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_tag_i    (div_tag),
    .in_quo_i    (div_quo),
    .out_valid_o (tone_o.valid),
    .out_ready_i (tone_o.ready),
    .out_o       (res)
  );

  assign tone_o.tone_on       = res.tone_on;
  assign tone_o.tone_freq_hz  = res.tone_freq_hz;
  assign tone_o.period_reload = res.period_reload;
  assign tone_o.compare_value = res.compare_value;
  assign tone_o.sound_ms      = res.sound_ms;
  assign tone_o.silence_ms    = res.silence_ms;
  assign tone_o.hold_tone     = res.hold_tone;
  assign tone_o.bad_note      = res.bad_note;

endmodule
